@@ design/rotation_matrix_to_euler_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for rotation_matrix_to_euler
// Concurrent checks clocked on clock; ASSERT_OFF removes them.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_DEFINES_SVH

`ifndef ASSERT_OFF
// check that is masked while reset is high
`define RME_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that also holds across reset
`define RME_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RME_ASSERT(lbl, prop, msg)
`define RME_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ design/rme_pkg.sv @@
// ---------------------------------------------------------------------------
// rme_pkg
// Widths, constants and the CORDIC step-angle table for the Euler block.
// ---------------------------------------------------------------------------
package rme_pkg;

   localparam int ELEM_W       = 20;   // matrix element, Q18
   localparam int ANG_W        = 16;   // output angle, Q7 degrees
   localparam int OPND_W       = 21;   // atan2 operand after negation
   localparam int CORDIC_W     = 32;   // CORDIC datapath
   localparam int ACC_W        = 26;   // angle accumulator, Q16 degrees
   localparam int SQRT_BITS    = 19;   // root of a value up to 2^36
   localparam int RAD_W        = 37;   // radicand width
   localparam int PRESCALE_SH  = 8;    // operands times 256
   localparam int CORDIC_STAGES_DEF = 18;

   localparam logic signed [ELEM_W-1:0] ONE_Q18    = 20'sd262144;
   localparam logic        [OPND_W-1:0] LOCK_LIMIT = 21'd262141;
   localparam logic signed [ACC_W-1:0]  DEG90_Q16  = 26'sd5898240;
   localparam logic signed [ANG_W-1:0]  OUT_LIMIT  = 16'sd23040;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_ASIN,
      SEL_A,
      SEL_B
   } sel_type;

   // atan(2^-i) in Q16 degrees
   function automatic logic signed [ACC_W-1:0] step_angle(input int i);
      logic signed [ACC_W-1:0] a;
      case (i)
         0:  a = 26'sd2949120;
         1:  a = 26'sd1740967;
         2:  a = 26'sd919879;
         3:  a = 26'sd466945;
         4:  a = 26'sd234379;
         5:  a = 26'sd117304;
         6:  a = 26'sd58666;
         7:  a = 26'sd29335;
         8:  a = 26'sd14668;
         9:  a = 26'sd7334;
         10: a = 26'sd3667;
         11: a = 26'sd1833;
         12: a = 26'sd917;
         13: a = 26'sd458;
         14: a = 26'sd229;
         15: a = 26'sd115;
         16: a = 26'sd57;
         17: a = 26'sd29;
         18: a = 26'sd14;
         19: a = 26'sd7;
         20: a = 26'sd4;
         21: a = 26'sd2;
         22: a = 26'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

@@ design/rotation_matrix_to_euler.sv @@
// ---------------------------------------------------------------------------
// rotation_matrix_to_euler
// Rotation matrix to three Euler angles for a selectable axis order.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one 3x3 matrix per request (nine Q18 elements), rsp_*
//   returns angle_x/y/z in Q7 degrees, negated. csr_* writes the axis
//   order (0 XYZ, 1 YXZ, 2 ZXY, 3 ZYX, 4 YZX, 5 XZY; other codes give
//   zero angles); write it only while the pipe is empty.
//   Pipe stages: decode, radicand c*c, 19 square-root stages (one root
//   bit each), a quarter-turn stage plus CORDIC_STAGES CORDIC stages,
//   and the output register. Throughput is one request per cycle unless
//   rsp_tready holds the pipe; three CORDIC lanes (arcsine and two atan2)
//   run side by side in the same pipe.
//   Reset clears all valid bits and sets the order to XYZ.
//   When rsp_tready is low with a result waiting, the whole pipe holds
//   and req_tready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module rotation_matrix_to_euler import rme_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // e_r0c0, e_r0c1, e_r0c2, e_r1c0, e_r1c1, e_r1c2, e_r2c0, e_r2c1,
   // e_r2c2 (20 bits each), 4 zero bits
   input  logic [183:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // angle_x, angle_y, angle_z (16 bits each)
   output logic [47:0]   rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_data
);

   `include "rotation_matrix_to_euler_defines.svh"

   localparam int PIPE_N = SQRT_BITS + 1;
   localparam int DEPTH  = CORDIC_STAGES + 23;

   typedef struct packed {
      logic [RAD_W-1:0]         rem;
      logic [SQRT_BITS-1:0]     root;
      logic signed [ELEM_W-1:0] c;
      logic signed [OPND_W-1:0] ay;
      logic signed [OPND_W-1:0] ax;
      logic signed [OPND_W-1:0] by;
      logic signed [OPND_W-1:0] bx;
      sel_type                  sx;
      sel_type                  sy;
      sel_type                  sz;
      logic                     lock;
   } pipe_type;

   typedef struct packed {
      sel_type sx;
      sel_type sy;
      sel_type sz;
      logic    lock;
   } route_type;

   logic                 en;
   logic [2:0]           order_ff;
   logic [DEPTH-1:0]     vld_ff;
   pipe_type             dec_ff, dec_in;
   pipe_type             pipe_ff [0:PIPE_N-1];
   route_type            route_ff[0:CORDIC_STAGES];
   logic [47:0]          out_ff, out_in;

   assign en         = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign rsp_tdata  = out_ff;
   assign csr_ready  = 1'b1;

   // elements in transposed order: m_ab is row b-1, column a-1
   logic signed [ELEM_W-1:0] m11, m21, m31, m12, m22, m32, m13, m23, m33;
   assign m11 = req_tdata[19:0];
   assign m21 = req_tdata[39:20];
   assign m31 = req_tdata[59:40];
   assign m12 = req_tdata[79:60];
   assign m22 = req_tdata[99:80];
   assign m32 = req_tdata[119:100];
   assign m13 = req_tdata[139:120];
   assign m23 = req_tdata[159:140];
   assign m33 = req_tdata[179:160];

   function automatic logic signed [OPND_W-1:0] pos(input logic signed [ELEM_W-1:0] m);
      return OPND_W'(m);
   endfunction

   function automatic logic signed [OPND_W-1:0] neg(input logic signed [ELEM_W-1:0] m);
      return -OPND_W'(m);
   endfunction

   function automatic logic signed [ELEM_W-1:0] clamp(input logic signed [ELEM_W-1:0] m);
      logic signed [ELEM_W-1:0] r;
      r = m;
      if (m > ONE_Q18) r = ONE_Q18;
      if (m < -ONE_Q18) r = -ONE_Q18;
      return r;
   endfunction

   function automatic logic locked(input logic signed [ELEM_W-1:0] m);
      logic signed [OPND_W-1:0] w;
      w = OPND_W'(m);
      if (w < 0) w = -w;
      return w > LOCK_LIMIT;
   endfunction

   // A is the atan2 that survives gimbal lock, B is dropped there
   always_comb begin
      dec_in      = '0;
      dec_in.sx   = SEL_ZERO;
      dec_in.sy   = SEL_ZERO;
      dec_in.sz   = SEL_ZERO;
      unique case (order_ff)
         3'd0: begin
            dec_in.c    = clamp(m13);
            dec_in.lock = locked(m13);
            dec_in.sy = SEL_ASIN; dec_in.sx = SEL_A; dec_in.sz = SEL_B;
            if (dec_in.lock) begin
               dec_in.ay = pos(m32); dec_in.ax = pos(m22);
            end else begin
               dec_in.ay = neg(m23); dec_in.ax = pos(m33);
            end
            dec_in.by = neg(m12); dec_in.bx = pos(m11);
         end
         3'd1: begin
            dec_in.c    = -clamp(m23);
            dec_in.lock = locked(m23);
            dec_in.sx = SEL_ASIN; dec_in.sy = SEL_A; dec_in.sz = SEL_B;
            if (dec_in.lock) begin
               dec_in.ay = neg(m31); dec_in.ax = pos(m11);
            end else begin
               dec_in.ay = pos(m13); dec_in.ax = pos(m33);
            end
            dec_in.by = pos(m21); dec_in.bx = pos(m22);
         end
         3'd2: begin
            dec_in.c    = clamp(m32);
            dec_in.lock = locked(m32);
            dec_in.sx = SEL_ASIN; dec_in.sz = SEL_A; dec_in.sy = SEL_B;
            if (dec_in.lock) begin
               dec_in.ay = pos(m21); dec_in.ax = pos(m11);
            end else begin
               dec_in.ay = neg(m12); dec_in.ax = pos(m22);
            end
            dec_in.by = neg(m31); dec_in.bx = pos(m33);
         end
         3'd3: begin
            dec_in.c    = -clamp(m31);
            dec_in.lock = locked(m31);
            dec_in.sy = SEL_ASIN; dec_in.sz = SEL_A; dec_in.sx = SEL_B;
            if (dec_in.lock) begin
               dec_in.ay = neg(m12); dec_in.ax = pos(m22);
            end else begin
               dec_in.ay = pos(m21); dec_in.ax = pos(m11);
            end
            dec_in.by = pos(m32); dec_in.bx = pos(m33);
         end
         3'd4: begin
            dec_in.c    = clamp(m21);
            dec_in.lock = locked(m21);
            dec_in.sz = SEL_ASIN; dec_in.sy = SEL_A; dec_in.sx = SEL_B;
            if (dec_in.lock) begin
               dec_in.ay = pos(m13); dec_in.ax = pos(m33);
            end else begin
               dec_in.ay = neg(m31); dec_in.ax = pos(m11);
            end
            dec_in.by = neg(m23); dec_in.bx = pos(m22);
         end
         3'd5: begin
            dec_in.c    = -clamp(m12);
            dec_in.lock = locked(m12);
            dec_in.sz = SEL_ASIN; dec_in.sx = SEL_A; dec_in.sy = SEL_B;
            if (dec_in.lock) begin
               dec_in.ay = neg(m23); dec_in.ax = pos(m33);
            end else begin
               dec_in.ay = pos(m32); dec_in.ax = pos(m22);
            end
            dec_in.by = pos(m13); dec_in.bx = pos(m11);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
         vld_ff   <= '0;
      end else begin
         if (csr_valid) order_ff <= csr_data;
         if (en) vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   // radicand 2^36 - c*c
   logic signed [2*ELEM_W-1:0] csq;
   pipe_type                   rad_in;
   assign csq = dec_ff.c * dec_ff.c;
   always_comb begin
      rad_in      = dec_ff;
      rad_in.rem  = (RAD_W'(1) << (RAD_W - 1)) - csq[RAD_W-1:0];
      rad_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dec_ff     <= dec_in;
         pipe_ff[0] <= rad_in;
      end
   end

   // one root bit per stage, MSB first
   for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
      localparam int K = SQRT_BITS - 1 - j;
      logic [RAD_W+1:0] trial;
      pipe_type         nxt;
      assign trial = ((RAD_W+2)'(pipe_ff[j].root) << (K + 1)) + ((RAD_W+2)'(1) << (2 * K));
      always_comb begin
         nxt = pipe_ff[j];
         if ((RAD_W+2)'(pipe_ff[j].rem) >= trial) begin
            nxt.rem  = pipe_ff[j].rem - trial[RAD_W-1:0];
            nxt.root = pipe_ff[j].root | (SQRT_BITS'(1) << K);
         end
      end
      always_ff @(posedge clock) begin
         if (en) pipe_ff[j+1] <= nxt;
      end
   end

   pipe_type                sq;
   logic signed [ACC_W-1:0] ang_s, ang_a, ang_b;
   assign sq = pipe_ff[PIPE_N-1];

   rme_cordic #(.STAGES(CORDIC_STAGES)) u_asin (
      .clock (clock), .en (en),
      .y_in  (OPND_W'(sq.c)),
      .x_in  (OPND_W'({1'b0, sq.root})),
      .angle (ang_s)
   );

   rme_cordic #(.STAGES(CORDIC_STAGES)) u_atan_a (
      .clock (clock), .en (en), .y_in (sq.ay), .x_in (sq.ax), .angle (ang_a)
   );

   rme_cordic #(.STAGES(CORDIC_STAGES)) u_atan_b (
      .clock (clock), .en (en), .y_in (sq.by), .x_in (sq.bx), .angle (ang_b)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         route_ff[0] <= '{sx: sq.sx, sy: sq.sy, sz: sq.sz, lock: sq.lock};
         for (int i = 0; i < CORDIC_STAGES; i++) route_ff[i+1] <= route_ff[i];
      end
   end

   function automatic logic [ANG_W-1:0] to_out(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W:0] t;
      logic signed [ACC_W:0] lim;
      t   = (-(ACC_W+1)'(a) + (ACC_W+1)'(256)) >>> 9;
      lim = (ACC_W+1)'(OUT_LIMIT);
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      return t[ANG_W-1:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] pick(
      input sel_type s, input logic lock,
      input logic signed [ACC_W-1:0] vs, input logic signed [ACC_W-1:0] va,
      input logic signed [ACC_W-1:0] vb);
      logic signed [ACC_W-1:0] r;
      case (s)
         SEL_ASIN: r = vs;
         SEL_A:    r = va;
         SEL_B:    r = lock ? '0 : vb;
         default:  r = '0;
      endcase
      return r;
   endfunction

   route_type rt;
   assign rt = route_ff[CORDIC_STAGES];

   always_comb begin
      out_in[15:0]  = to_out(pick(rt.sx, rt.lock, ang_s, ang_a, ang_b));
      out_in[31:16] = to_out(pick(rt.sy, rt.lock, ang_s, ang_a, ang_b));
      out_in[47:32] = to_out(pick(rt.sz, rt.lock, ang_s, ang_a, ang_b));
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

   `RME_ASSERT(a_stall_holds_pipe, !en |=> $stable(vld_ff), "pipe moved during stall")
   `RME_ASSERT(a_out_range, rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= OUT_LIMIT && $signed(rsp_tdata[15:0]) >= -OUT_LIMIT && $signed(rsp_tdata[31:16]) <= OUT_LIMIT && $signed(rsp_tdata[31:16]) >= -OUT_LIMIT && $signed(rsp_tdata[47:32]) <= OUT_LIMIT && $signed(rsp_tdata[47:32]) >= -OUT_LIMIT), "angle out of range")
   `RME_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid && req_tready, "pipe not empty after reset")

endmodule

@@ design/rme_cordic.sv @@
// ---------------------------------------------------------------------------
// rme_cordic
// Pipelined vectoring CORDIC atan2, one operand pair per cycle while en is high.
// ---------------------------------------------------------------------------
module rme_cordic import rme_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [OPND_W-1:0] y_in,
   input  logic signed [OPND_W-1:0] x_in,
   output logic signed [ACC_W-1:0]  angle
);

   logic signed [CORDIC_W-1:0] x_ff   [0:STAGES];
   logic signed [CORDIC_W-1:0] y_ff   [0:STAGES];
   logic signed [ACC_W-1:0]    acc_ff [0:STAGES];
   logic                       zero_ff[0:STAGES];

   logic signed [CORDIC_W-1:0] xs, ys;
   logic signed [CORDIC_W-1:0] x0_in, y0_in;
   logic signed [ACC_W-1:0]    acc0_in;

   assign xs = CORDIC_W'(x_in) <<< PRESCALE_SH;
   assign ys = CORDIC_W'(y_in) <<< PRESCALE_SH;

   // left half plane: turn by a quarter first
   always_comb begin
      x0_in   = xs;
      y0_in   = ys;
      acc0_in = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            x0_in   = ys;
            y0_in   = -xs;
            acc0_in = DEG90_Q16;
         end else begin
            x0_in   = -ys;
            y0_in   = xs;
            acc0_in = -DEG90_Q16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         acc_ff[0]  <= acc0_in;
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [CORDIC_W-1:0] dx, dy;
      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (!y_ff[i][CORDIC_W-1]) begin
               x_ff[i+1]   <= x_ff[i] + dy;
               y_ff[i+1]   <= y_ff[i] - dx;
               acc_ff[i+1] <= acc_ff[i] + step_angle(i);
            end else begin
               x_ff[i+1]   <= x_ff[i] - dy;
               y_ff[i+1]   <= y_ff[i] + dx;
               acc_ff[i+1] <= acc_ff[i] - step_angle(i);
            end
         end
      end
   end

   assign angle = zero_ff[STAGES] ? '0 : acc_ff[STAGES];

endmodule
